// File: hdl/sgs_pkg.sv
// Shared constants, types and decode functions for the two-channel smoother.
`default_nettype none

package sgs_pkg;

	// Sample width default and fixed filter geometry
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int MAX_TAPS         = 9;
	localparam int HIST_DEPTH       = MAX_TAPS - 1;
	localparam int FILL_W           = 4;
	localparam int COEF_W           = 7;
	localparam int NORM_W           = 8;

	// Growth of the weighted sum over the sample width: |sum| <= 315 * 2^(W-1)
	localparam int SUM_GROW = 9;
	// Bits dropped by a quotient: every norm is at least 16
	localparam int QUO_DROP = 4;

	// Registered stages between the input beat and the result register
	localparam int PIPE_STAGES = 7;

	// Norms and rounding offsets
	localparam logic [NORM_W-1:0] NORM_5 = 8'd35;
	localparam logic [NORM_W-1:0] NORM_7 = 8'd21;
	localparam logic [NORM_W-1:0] NORM_9 = 8'd231;
	localparam logic [NORM_W-1:0] HALF_5 = (NORM_5 - 8'd1) / 8'd2;
	localparam logic [NORM_W-1:0] HALF_7 = (NORM_7 - 8'd1) / 8'd2;
	localparam logic [NORM_W-1:0] HALF_9 = (NORM_9 - 8'd1) / 8'd2;

	// Samples held before each window is complete
	localparam logic [FILL_W-1:0] FILL_5 = 4'd4;
	localparam logic [FILL_W-1:0] FILL_7 = 4'd6;
	localparam logic [FILL_W-1:0] FILL_9 = 4'd8;

	typedef enum logic [1:0] {
		WIN_5 = 2'd0,
		WIN_7 = 2'd1,
		WIN_9 = 2'd2
	} win_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_row_t [MAX_TAPS];

	// Coefficients by sample age, age 0 being the current input; unused ages weigh zero
	localparam coef_row_t COEF_5 = '{-7'sd3, 7'sd12, 7'sd17, 7'sd12, -7'sd3,
		7'sd0, 7'sd0, 7'sd0, 7'sd0};
	localparam coef_row_t COEF_7 = '{-7'sd2, 7'sd3, 7'sd6, 7'sd7, 7'sd6, 7'sd3, -7'sd2,
		7'sd0, 7'sd0};
	localparam coef_row_t COEF_9 = '{-7'sd21, 7'sd14, 7'sd39, 7'sd54, 7'sd59, 7'sd54,
		7'sd39, 7'sd14, -7'sd21};

	// Control between the top level and a channel datapath
	typedef struct packed {
		logic                   accept;
		logic [PIPE_STAGES-1:0] en;
		win_t                   win;
		logic                   smooth_s7;
	} sgs_ctl_t;

	// Map the register value to a window; the spare code means five points
	function automatic win_t win_decode(input logic [1:0] sel);
		win_t w;
		unique case (sel)
			WIN_7:   w = WIN_7;
			WIN_9:   w = WIN_9;
			default: w = WIN_5;
		endcase
		return w;
	endfunction

	function automatic coef_row_t coef_row(input win_t w);
		coef_row_t r;
		unique case (w)
			WIN_7:   r = COEF_7;
			WIN_9:   r = COEF_9;
			default: r = COEF_5;
		endcase
		return r;
	endfunction

	function automatic logic [NORM_W-1:0] norm_of(input win_t w);
		logic [NORM_W-1:0] n;
		unique case (w)
			WIN_7:   n = NORM_7;
			WIN_9:   n = NORM_9;
			default: n = NORM_5;
		endcase
		return n;
	endfunction

	function automatic logic [NORM_W-1:0] half_of(input win_t w);
		logic [NORM_W-1:0] h;
		unique case (w)
			WIN_7:   h = HALF_7;
			WIN_9:   h = HALF_9;
			default: h = HALF_5;
		endcase
		return h;
	endfunction

	function automatic logic [FILL_W-1:0] fill_needed(input win_t w);
		logic [FILL_W-1:0] f;
		unique case (w)
			WIN_7:   f = FILL_7;
			WIN_9:   f = FILL_9;
			default: f = FILL_5;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// File: hdl/sgs_if.sv
// Valid/ready channel interfaces for samples, results and the configuration write.
`default_nettype none

interface sgs_in_if #(parameter int SAMPLE_WIDTH = sgs_pkg::SAMPLE_WIDTH_DEF);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_a;
	logic signed [SAMPLE_WIDTH-1:0] sample_b;

	modport source (output valid, output sample_a, output sample_b, input ready);
	modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface sgs_out_if #(parameter int SAMPLE_WIDTH = sgs_pkg::SAMPLE_WIDTH_DEF);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] smoothed_a;
	logic signed [SAMPLE_WIDTH-1:0] smoothed_b;
	logic                           is_smoothed;
	logic                           clipped;

	modport source (output valid, output smoothed_a, output smoothed_b,
		output is_smoothed, output clipped, input ready);
	modport sink   (input valid, input smoothed_a, input smoothed_b,
		input is_smoothed, input clipped, output ready);
endinterface

interface sgs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] window_select;

	modport source (output valid, output window_select, input ready);
	modport sink   (input valid, input window_select, output ready);
endinterface

`default_nettype wire

// File: hdl/sgs_channel.sv
// One channel: delay line, weighted sum, rounding divide by the norm and saturation.
`default_nettype none

module sgs_channel #(
	parameter int SAMPLE_WIDTH = sgs_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sgs_pkg::sgs_ctl_t              ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH-1:0] result,
	output logic                           clip
);
	import sgs_pkg::*;

	localparam int W    = SAMPLE_WIDTH;
	localparam int P_W  = W + COEF_W;
	localparam int S_W  = W + SUM_GROW;
	localparam int Y_W  = S_W - 1;
	localparam int K    = Y_W / 2;
	localparam int YH_W = Y_W - K;
	localparam int QH_W = YH_W - QUO_DROP;
	localparam int Z_W  = NORM_W + K;
	localparam int M1_W = YH_W + QUO_DROP;
	localparam int M2_W = Z_W + QUO_DROP;
	localparam int SH1  = YH_W + NORM_W;
	localparam int SH2  = Z_W + NORM_W;
	localparam int P1_W = YH_W + M1_W;
	localparam int P2_W = Z_W + M2_W;
	localparam int QN_W = QH_W + NORM_W;
	localparam int Q_W  = QH_W + K;

	// Reciprocals: floor(x / d) == (x * ceil(2^(N+8) / d)) >> (N+8) for any N-bit x
	localparam logic [63:0] M1_5_FULL = ((64'd1 << SH1) + 64'(NORM_5) - 64'd1) / 64'(NORM_5);
	localparam logic [63:0] M1_7_FULL = ((64'd1 << SH1) + 64'(NORM_7) - 64'd1) / 64'(NORM_7);
	localparam logic [63:0] M1_9_FULL = ((64'd1 << SH1) + 64'(NORM_9) - 64'd1) / 64'(NORM_9);
	localparam logic [63:0] M2_5_FULL = ((64'd1 << SH2) + 64'(NORM_5) - 64'd1) / 64'(NORM_5);
	localparam logic [63:0] M2_7_FULL = ((64'd1 << SH2) + 64'(NORM_7) - 64'd1) / 64'(NORM_7);
	localparam logic [63:0] M2_9_FULL = ((64'd1 << SH2) + 64'(NORM_9) - 64'd1) / 64'(NORM_9);

	// Saturation bounds on the quotient magnitude
	localparam logic [Q_W-1:0] MAG_POS = {{(Q_W-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [Q_W-1:0] MAG_NEG = {{(Q_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0]   hist_q [HIST_DEPTH];

	logic signed [W-1:0]   win_s1 [MAX_TAPS];
	win_t                  mode_s1;

	logic signed [P_W-1:0] prod_s2 [MAX_TAPS];
	win_t                  mode_s2;
	logic signed [W-1:0]   raw_s2;

	logic signed [S_W-1:0] sum_s3;
	win_t                  mode_s3;
	logic signed [W-1:0]   raw_s3;

	logic [Y_W-1:0]        y_s4;
	logic                  neg_s4;
	win_t                  mode_s4;
	logic signed [W-1:0]   raw_s4;

	logic [QH_W-1:0]       qh_s5;
	logic [YH_W-1:0]       yh_s5;
	logic [K-1:0]          yl_s5;
	logic                  neg_s5;
	win_t                  mode_s5;
	logic signed [W-1:0]   raw_s5;

	logic [Z_W-1:0]        z_s6;
	logic [QH_W-1:0]       qh_s6;
	logic                  neg_s6;
	win_t                  mode_s6;
	logic signed [W-1:0]   raw_s6;

	logic [K-1:0]          ql_s7;
	logic [QH_W-1:0]       qh_s7;
	logic                  neg_s7;
	logic signed [W-1:0]   raw_s7;

	coef_row_t             coef;
	logic signed [P_W-1:0] prod [MAX_TAPS];
	logic signed [S_W-1:0] ext [MAX_TAPS];
	logic signed [S_W-1:0] sum;
	logic                  neg;
	logic [S_W-1:0]        mag_base;
	logic [S_W-1:0]        y_bias;
	logic [S_W-1:0]        y_full;
	logic [M1_W-1:0]       m1;
	logic [P1_W-1:0]       p1;
	logic [QN_W-1:0]       qn;
	logic [YH_W-1:0]       rdiff;
	logic [M2_W-1:0]       m2;
	logic [P2_W-1:0]       p2;
	logic [Q_W-1:0]        mag;

	// Shift the accepted sample into the delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HIST_DEPTH; j++) begin
				hist_q[j] <= '0;
			end
		end else if (ctl.accept) begin
			hist_q[0] <= sample;
			for (int j = 1; j < HIST_DEPTH; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end
	end

	// Capture the window: current sample plus the delay line
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			win_s1[0] <= sample;
			for (int j = 1; j < MAX_TAPS; j++) begin
				win_s1[j] <= hist_q[j-1];
			end
			mode_s1 <= ctl.win;
		end
	end

	// Weight each sample by its coefficient
	always_comb begin
		coef = coef_row(mode_s1);
		for (int j = 0; j < MAX_TAPS; j++) begin
			prod[j] = P_W'(coef[j]) * P_W'(win_s1[j]);
		end
	end

	// Add the products in a balanced tree
	always_comb begin
		for (int j = 0; j < MAX_TAPS; j++) begin
			ext[j] = S_W'(prod_s2[j]);
		end
		sum = ((ext[0] + ext[1]) + (ext[2] + ext[3]))
			+ ((ext[4] + ext[5]) + (ext[6] + ext[7])) + ext[8];
	end

	// Fold the sign away and add half the norm for round-half-away-from-zero
	always_comb begin
		neg      = sum_s3[S_W-1];
		mag_base = neg ? ~sum_s3 : sum_s3;
		y_bias   = S_W'(half_of(mode_s3)) + S_W'(neg);
		y_full   = mag_base + y_bias;
	end

	// High part quotient by reciprocal multiply
	always_comb begin
		unique case (mode_s4)
			WIN_7:   m1 = M1_7_FULL[M1_W-1:0];
			WIN_9:   m1 = M1_9_FULL[M1_W-1:0];
			default: m1 = M1_5_FULL[M1_W-1:0];
		endcase
		p1 = P1_W'(y_s4[Y_W-1:K]) * P1_W'(m1);
	end

	// High part remainder joins the low bits
	always_comb begin
		qn    = QN_W'(qh_s5) * QN_W'(norm_of(mode_s5));
		rdiff = yh_s5 - qn[YH_W-1:0];
	end

	// Low part quotient by reciprocal multiply
	always_comb begin
		unique case (mode_s6)
			WIN_7:   m2 = M2_7_FULL[M2_W-1:0];
			WIN_9:   m2 = M2_9_FULL[M2_W-1:0];
			default: m2 = M2_5_FULL[M2_W-1:0];
		endcase
		p2 = P2_W'(z_s6) * P2_W'(m2);
	end

	// Advance the datapath stages
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			prod_s2 <= prod;
			mode_s2 <= mode_s1;
			raw_s2  <= win_s1[0];
		end
		if (ctl.en[2]) begin
			sum_s3  <= sum;
			mode_s3 <= mode_s2;
			raw_s3  <= raw_s2;
		end
		if (ctl.en[3]) begin
			y_s4    <= y_full[Y_W-1:0];
			neg_s4  <= neg;
			mode_s4 <= mode_s3;
			raw_s4  <= raw_s3;
		end
		if (ctl.en[4]) begin
			qh_s5   <= p1[SH1 +: QH_W];
			yh_s5   <= y_s4[Y_W-1:K];
			yl_s5   <= y_s4[K-1:0];
			neg_s5  <= neg_s4;
			mode_s5 <= mode_s4;
			raw_s5  <= raw_s4;
		end
		if (ctl.en[5]) begin
			z_s6    <= {rdiff[NORM_W-1:0], yl_s5};
			qh_s6   <= qh_s5;
			neg_s6  <= neg_s5;
			mode_s6 <= mode_s5;
			raw_s6  <= raw_s5;
		end
		if (ctl.en[6]) begin
			ql_s7  <= p2[SH2 +: K];
			qh_s7  <= qh_s6;
			neg_s7 <= neg_s6;
			raw_s7 <= raw_s6;
		end
	end

	// Restore the sign, clamp to the sample range, or pass the input through
	always_comb begin
		mag = {qh_s7, ql_s7};
		if (!ctl.smooth_s7) begin
			result = raw_s7;
			clip   = 1'b0;
		end else if (neg_s7) begin
			clip   = mag > MAG_NEG;
			result = clip ? {1'b1, {(W-1){1'b0}}}
				: ~mag[W-1:0] + {{(W-1){1'b0}}, 1'b1};
		end else begin
			clip   = mag > MAG_POS;
			result = clip ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hdl/savitzky_golay_smoother_2ch.sv
// Top level of the two-channel quadratic Savitzky-Golay smoother.
//
// Each input beat carries one signed sample per channel and yields exactly one result
// beat. The window register picks 5, 7 or 9 points (the spare code acts as 5); until
// enough samples are held for the active window the inputs come back unchanged with
// is_smoothed low, afterwards each result is the weighted window sum divided by the
// norm, rounded half away from zero and clamped, with clipped set when either channel
// clamped. The block takes one beat per clock while results are taken; each result
// passes one capture stage, the product and sum stages, a stage
// that folds the sign and adds the rounding offset, and the divide by the norm done as
// two reciprocal-multiply steps with a remainder stage between them, ahead of the
// result register. Every stage holds its beat under back-pressure and fills its
// bubbles, so input keeps flowing while a result waits until eight beats are held.
// Write the window register only while the block is idle; the fill count is kept across
// such writes.
`default_nettype none

module savitzky_golay_smoother_2ch #(
	parameter int SAMPLE_WIDTH = sgs_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sgs_cfg_if.sink   cfg,
	sgs_in_if.sink    samples,
	sgs_out_if.source results
);
	import sgs_pkg::*;

	localparam int LAST = PIPE_STAGES - 1;

	win_t                           win_q;
	logic [FILL_W-1:0]              fill_count_q;
	logic [PIPE_STAGES-1:0]         vld_q;
	logic [PIPE_STAGES-1:0]         smooth_q;
	logic                           out_vld_q;
	logic signed [SAMPLE_WIDTH-1:0] out_a_q;
	logic signed [SAMPLE_WIDTH-1:0] out_b_q;
	logic                           out_smooth_q;
	logic                           out_clip_q;

	logic [PIPE_STAGES-1:0]         en;
	logic                           en_out;
	logic                           accept;
	logic                           smooth_in;
	sgs_ctl_t                       ctl;
	logic signed [SAMPLE_WIDTH-1:0] res_a;
	logic signed [SAMPLE_WIDTH-1:0] res_b;
	logic                           clip_a;
	logic                           clip_b;

	// Stage enables: a stage loads when empty or when its beat moves on
	always_comb begin
		en_out   = !out_vld_q || results.ready;
		en[LAST] = !vld_q[LAST] || en_out;
		for (int i = LAST - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign samples.ready = en[0];
	assign accept        = samples.valid && en[0];
	assign smooth_in     = fill_count_q >= fill_needed(win_q);
	assign cfg.ready     = 1'b1;

	assign ctl.accept    = accept;
	assign ctl.en        = en;
	assign ctl.win       = win_q;
	assign ctl.smooth_s7 = smooth_q[LAST];

	// Window register and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= WIN_5;
			fill_count_q <= '0;
		end else begin
			if (cfg.valid) begin
				win_q <= win_decode(cfg.window_select);
			end
			if (accept && fill_count_q < FILL_W'(HIST_DEPTH)) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
		end
	end

	// Advance valid and smoothing flags along the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			smooth_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en[0]) begin
				vld_q[0]    <= accept;
				smooth_q[0] <= smooth_in;
			end
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i]    <= vld_q[i-1];
					smooth_q[i] <= smooth_q[i-1];
				end
			end
			if (en_out) begin
				out_vld_q <= vld_q[LAST];
			end
		end
	end

	sgs_channel #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chan_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (samples.sample_a),
		.result (res_a),
		.clip   (clip_a)
	);

	sgs_channel #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chan_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (samples.sample_b),
		.result (res_b),
		.clip   (clip_b)
	);

	// Hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (en_out) begin
			out_a_q      <= res_a;
			out_b_q      <= res_b;
			out_smooth_q <= smooth_q[LAST];
			out_clip_q   <= clip_a || clip_b;
		end
	end

	assign results.valid       = out_vld_q;
	assign results.smoothed_a  = out_a_q;
	assign results.smoothed_b  = out_b_q;
	assign results.is_smoothed = out_smooth_q;
	assign results.clipped     = out_clip_q;

	// Pass-through beats never report clamping
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.is_smoothed |-> !results.clipped)
		else $error("clipped set on a pass-through result");

	// Fill count moves only with an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(fill_count_q))
		else $error("fill count changed without an input beat");

	// Smoothing never starts before the smallest window is full
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && smooth_in |-> fill_count_q >= FILL_5)
		else $error("smoothing flagged with too few samples held");

	// An accepted beat enters the capture stage
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_q[0])
		else $error("accepted beat lost at the capture stage");

endmodule

`default_nettype wire
